### design/lrupr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared widths, types, the controller states and the frame count clamp.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int NUM_W      = FRAME_W + 1;
  localparam int PAGE_W     = 16;
  localparam int RANK_W     = 4;
  localparam int CFG_W      = 5;
  localparam int COUNT_W    = 32;

  typedef logic [FRAME_W-1:0]    frame_idx_t;
  typedef logic [NUM_W-1:0]      frame_num_t;
  typedef logic [PAGE_W-1:0]     page_t;
  typedef logic [RANK_W-1:0]     rank_t;
  typedef logic [RANK_W:0]       rank_ext_t;
  typedef logic [CFG_W-1:0]      cfg_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [MAX_FRAMES-1:0] valid_vec_t;
  typedef rank_t [MAX_FRAMES-1:0] rank_vec_t;

  localparam rank_t RANK_MAX         = '1;
  localparam rank_ext_t RANK_EMPTY   = {1'b1, {RANK_W{1'b0}}};
  localparam cfg_t FRAMES_RESET      = CFG_W'(3);
  localparam count_t COUNT_MAX       = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic       touch;
    logic       fill;
    frame_idx_t frame;
    rank_ext_t  old_rank;
    frame_num_t active;
  } touch_cmd_t;

  function automatic frame_num_t active_frames(input cfg_t cfg);
    frame_num_t n;
    if (cfg == '0) begin
      n = NUM_W'(1);
    end else if (cfg > CFG_W'(MAX_FRAMES)) begin
      n = NUM_W'(MAX_FRAMES);
    end else begin
      n = NUM_W'(cfg);
    end
    return n;
  endfunction

endpackage

### design/lrupr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement request channel
// Carries one page reference per transfer.
// ----------------------------------------------------------------------------
interface lrupr_req_if;
  logic                 valid;
  logic                 ready;
  lrupr_pkg::page_t     page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

### design/lrupr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement result channel
// Carries the outcome of one page reference per transfer.
// ----------------------------------------------------------------------------
interface lrupr_rsp_if;
  logic                   valid;
  logic                   ready;
  logic                   hit;
  lrupr_pkg::frame_idx_t  frame_index;
  logic                   evicted_valid;
  lrupr_pkg::page_t       evicted_page;
  lrupr_pkg::count_t      fault_count;
  lrupr_pkg::count_t      hit_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, output hit_count, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_count, input hit_count, output ready);
endinterface

### design/lrupr_recency.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement recency tracker
// Holds the frame valid bits and recency ranks and applies one touch at a time.
// ----------------------------------------------------------------------------
module lrupr_recency (
  input  logic                   clk,
  input  logic                   rst,
  input  lrupr_pkg::touch_cmd_t  cmd,
  output lrupr_pkg::valid_vec_t  valid,
  output lrupr_pkg::rank_vec_t   rank
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rank  <= '0;
    end else if (cmd.touch) begin
      for (int g = 0; g < lrupr_pkg::MAX_FRAMES; g++) begin
        if (lrupr_pkg::frame_idx_t'(g) == cmd.frame) begin
          rank[g] <= '0;
          if (cmd.fill) begin
            valid[g] <= 1'b1;
          end
        end else if ((lrupr_pkg::frame_num_t'(g) < cmd.active) && valid[g] &&
                     ({1'b0, rank[g]} < cmd.old_rank) && (rank[g] != lrupr_pkg::RANK_MAX)) begin
          rank[g] <= rank[g] + 1'b1;
        end
      end
    end
  end

endmodule

### design/lru_page_replacement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Looks up each page reference in the active frames, on a fault fills a free
// frame or else the LRU frame and reports hit, frame, eviction and running counts.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer carries
//  request   sink       page_number
//  result    source     hit, frame_index, evicted_valid, evicted_page,
//                       fault_count, hit_count
//  cfg_wr    write only frames_in_use
//
// The active frame count runs from 1 to 16, and for each reference
// the page memory is scanned one frame per cycle through its single read port.
// Reset empties all frames, clears ranks and counts and sets frames_in_use to 3.
// A new reference is accepted while a result still waits; its commit then
// waits until the result register is free.
module lru_page_replacement_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  lrupr_pkg::cfg_t    cfg_wr_data,
  lrupr_req_if.sink          request,
  lrupr_rsp_if.source        result
);

  lrupr_pkg::state_t     state;
  lrupr_pkg::state_t     state_next;
  lrupr_pkg::cfg_t       frames_in_use;
  lrupr_pkg::page_t      page;
  lrupr_pkg::frame_num_t active;
  lrupr_pkg::frame_num_t issue_idx;
  logic                  cmp_valid;
  lrupr_pkg::frame_idx_t cmp_idx;
  lrupr_pkg::page_t      rd_data;
  lrupr_pkg::page_t      mem [lrupr_pkg::MAX_FRAMES];

  logic                  found;
  lrupr_pkg::frame_idx_t hit_idx;
  logic                  have_empty;
  lrupr_pkg::frame_idx_t empty_idx;
  lrupr_pkg::rank_t      best_rank;
  lrupr_pkg::frame_idx_t best_idx;
  lrupr_pkg::page_t      best_page;

  lrupr_pkg::count_t     faults;
  lrupr_pkg::count_t     hits;
  lrupr_pkg::count_t     faults_next;
  lrupr_pkg::count_t     hits_next;

  logic                  out_valid;
  logic                  out_hit;
  lrupr_pkg::frame_idx_t out_frame;
  logic                  out_evicted;
  lrupr_pkg::page_t      out_evicted_page;
  lrupr_pkg::count_t     out_faults;
  lrupr_pkg::count_t     out_hits;

  logic                  in_ready;
  logic                  accept;
  logic                  rd_en;
  logic                  out_free;
  logic                  commit;
  logic                  last_issue;
  lrupr_pkg::frame_idx_t commit_frame;
  lrupr_pkg::rank_ext_t  commit_old_rank;
  logic                  commit_evict;
  lrupr_pkg::touch_cmd_t touch_cmd;
  lrupr_pkg::valid_vec_t frame_valid;
  lrupr_pkg::rank_vec_t  frame_rank;

  assign accept     = request.valid && in_ready;
  assign out_free   = !out_valid || result.ready;
  assign last_issue = (issue_idx + lrupr_pkg::frame_num_t'(1)) == active;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lrupr_pkg::FRAMES_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrupr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lrupr_pkg::ST_IDLE: begin
        if (request.valid) begin
          state_next = lrupr_pkg::ST_SCAN;
        end
      end
      lrupr_pkg::ST_SCAN: begin
        if (last_issue) begin
          state_next = lrupr_pkg::ST_DRAIN;
        end
      end
      lrupr_pkg::ST_DRAIN: begin
        state_next = lrupr_pkg::ST_COMMIT;
      end
      lrupr_pkg::ST_COMMIT: begin
        if (out_free) begin
          state_next = lrupr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrupr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    commit   = 1'b0;
    case (state)
      lrupr_pkg::ST_IDLE:   in_ready = 1'b1;
      lrupr_pkg::ST_SCAN:   rd_en    = 1'b1;
      lrupr_pkg::ST_DRAIN:  in_ready = 1'b0;
      lrupr_pkg::ST_COMMIT: commit   = out_free;
      default:              in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[issue_idx[lrupr_pkg::FRAME_W-1:0]];
    end
    if (commit && !found) begin
      mem[commit_frame] <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmp_idx   <= issue_idx[lrupr_pkg::FRAME_W-1:0];
      issue_idx <= issue_idx + lrupr_pkg::frame_num_t'(1);
    end else if (accept) begin
      issue_idx <= '0;
    end
    if (accept) begin
      page   <= request.page_number;
      active <= lrupr_pkg::active_frames(frames_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      have_empty <= 1'b0;
    end else if (accept) begin
      found      <= 1'b0;
      have_empty <= 1'b0;
    end else if (cmp_valid) begin
      if (!found && frame_valid[cmp_idx] && (rd_data == page)) begin
        found   <= 1'b1;
        hit_idx <= cmp_idx;
      end
      if (!have_empty && !frame_valid[cmp_idx]) begin
        have_empty <= 1'b1;
        empty_idx  <= cmp_idx;
      end
      if ((cmp_idx == '0) || (frame_rank[cmp_idx] > best_rank)) begin
        best_rank <= frame_rank[cmp_idx];
        best_idx  <= cmp_idx;
        best_page <= rd_data;
      end
    end
  end

  always_comb begin
    commit_evict = 1'b0;
    if (found) begin
      commit_frame    = hit_idx;
      commit_old_rank = {1'b0, frame_rank[hit_idx]};
    end else if (have_empty) begin
      commit_frame    = empty_idx;
      commit_old_rank = lrupr_pkg::RANK_EMPTY;
    end else begin
      commit_frame    = best_idx;
      commit_old_rank = {1'b0, best_rank};
      commit_evict    = 1'b1;
    end
    faults_next = faults;
    hits_next   = hits;
    if (found) begin
      if (hits != lrupr_pkg::COUNT_MAX) begin
        hits_next = hits + 1'b1;
      end
    end else if (faults != lrupr_pkg::COUNT_MAX) begin
      faults_next = faults + 1'b1;
    end
  end

  assign touch_cmd = '{touch: commit, fill: !found, frame: commit_frame,
                       old_rank: commit_old_rank, active: active};

  lrupr_recency u_recency (
    .clk   (clk),
    .rst   (rst),
    .cmd   (touch_cmd),
    .valid (frame_valid),
    .rank  (frame_rank)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      faults    <= '0;
      hits      <= '0;
      out_valid <= 1'b0;
    end else if (commit) begin
      faults    <= faults_next;
      hits      <= hits_next;
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit          <= found;
      out_frame        <= commit_frame;
      out_evicted      <= commit_evict;
      out_evicted_page <= commit_evict ? best_page : '0;
      out_faults       <= faults_next;
      out_hits         <= hits_next;
    end
  end

  assign request.ready        = in_ready;
  assign result.valid         = out_valid;
  assign result.hit           = out_hit;
  assign result.frame_index   = out_frame;
  assign result.evicted_valid = out_evicted;
  assign result.evicted_page  = out_evicted_page;
  assign result.fault_count   = out_faults;
  assign result.hit_count     = out_hits;

endmodule
